// ===== design/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// shared field widths, command codes and status codes of the periodic send
// scheduler
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 16;
   localparam int PER_W    = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SAT   = 2'd3;

endpackage

// ===== design/periodic_send_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_send_scheduler
// table of periodic receivers; a send picks the earliest due receiver
//
// A command is transferred at a rising edge with start high and busy low.
// Each command gives one result, shown for one cycle with rsp_strobe high.
// Clear, add and unused commands answer in the cycle after the transfer and
// leave busy low, so a new command may follow at once.
// A send on a non-empty table reads the table one entry a cycle through the
// single read port of the table memory, then writes the advanced due time
// back, busy staying high until the result is given. A send on an empty
// table answers in the next cycle.
// rsp_entry_count always shows the low five bits of the receiver count.
// Reset empties the table and drops any command in progress; table contents
// are not cleared, entries at or above the count are never used.
// The receiver cannot stall: each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module periodic_send_scheduler
   import pss_pkg::*;
#(
   parameter int MAX_RECEIVERS = 16,
   parameter int DUE_BITS      = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ID_W-1:0]     req_receiver_id,
   input  logic [PER_W-1:0]    req_period,
   output logic                rsp_strobe,
   output logic [ID_W-1:0]     rsp_chosen_id,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_entry_count
);

   localparam int IDX_W  = $clog2(MAX_RECEIVERS);
   localparam int UC_W   = $clog2(MAX_RECEIVERS + 1);
   localparam int DATA_W = ID_W + PER_W + DUE_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   state_type             state_ff;
   logic [UC_W-1:0]       used_count_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [ID_W-1:0]       best_id_ff;
   logic [PER_W-1:0]      best_per_ff;
   logic [DUE_BITS-1:0]   best_due_ff;
   logic                  rsp_strobe_ff;
   logic [ID_W-1:0]       rsp_chosen_id_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic                  accept;
   logic                  full;
   logic                  last;
   logic                  better;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_W-1:0]     wr_data;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_W-1:0]     rd_data;
   logic [ID_W-1:0]       rd_id;
   logic [PER_W-1:0]      rd_per;
   logic [DUE_BITS-1:0]   rd_due;
   logic [DUE_BITS:0]     due_sum;
   logic                  sat;
   logic [DUE_BITS-1:0]   new_due;
   logic [UC_W+COUNT_W-1:0] count_ext;

   pss_table #(
      .DEPTH  (MAX_RECEIVERS),
      .DATA_W (DATA_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (used_count_ff == UC_W'(MAX_RECEIVERS));
   assign last   = ((UC_W'(idx_ff) + UC_W'(1)) == used_count_ff);

   assign rd_id  = rd_data[DATA_W-1 -: ID_W];
   assign rd_per = rd_data[DUE_BITS +: PER_W];
   assign rd_due = rd_data[DUE_BITS-1:0];

   assign better = (idx_ff == '0) || (rd_due < best_due_ff) ||
                   ((rd_due == best_due_ff) && (rd_id < best_id_ff));

   assign due_sum = {1'b0, best_due_ff} + (DUE_BITS+1)'(best_per_ff);
   assign sat     = due_sum[DUE_BITS];
   assign new_due = sat ? '1 : due_sum[DUE_BITS-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = used_count_ff[IDX_W-1:0];
      wr_data = {req_receiver_id, req_period, DUE_BITS'(req_period)};
      rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_ADD) && !full) begin
               wr_en = 1'b1;
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff + IDX_W'(1);
         end
         ST_UPDATE: begin
            wr_en   = 1'b1;
            wr_addr = best_idx_ff;
            wr_data = {best_id_ff, best_per_ff, new_due};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_chosen_id_ff <= '0;
                  rsp_status_ff    <= ST_OK;
                  case (req_cmd)
                     CMD_CLEAR: begin
                        used_count_ff <= '0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     CMD_ADD: begin
                        rsp_strobe_ff <= 1'b1;
                        if (full) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           used_count_ff <= used_count_ff + UC_W'(1);
                        end
                     end
                     CMD_SEND: begin
                        if (used_count_ff == '0) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= ST_EMPTY;
                        end else begin
                           idx_ff   <= '0;
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (better) begin
                  best_idx_ff <= idx_ff;
                  best_id_ff  <= rd_id;
                  best_per_ff <= rd_per;
                  best_due_ff <= rd_due;
               end
               if (last) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            ST_UPDATE: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_chosen_id_ff <= best_id_ff;
               rsp_status_ff    <= sat ? ST_SAT : ST_OK;
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign count_ext       = {{COUNT_W{1'b0}}, used_count_ff};
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_chosen_id   = rsp_chosen_id_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = count_ext[COUNT_W-1:0];

   // results only leave once the sequencer is back to idle
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= UC_W'(MAX_RECEIVERS))
      else $error("receiver count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (UC_W'(idx_ff) < used_count_ff))
      else $error("scan beyond registered entries");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_CLEAR)) |=> (rsp_strobe && (rsp_entry_count == '0)))
      else $error("clear transfer without empty result");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (rsp_strobe && !busy))
      else $error("send writeback without result");

endmodule

// ===== design/pss_table.sv =====
// ----------------------------------------------------------------------------
// pss_table
// receiver table: one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module pss_table #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
